// ===== sv/ptd_pkg.sv =====
`default_nettype none
package ptd_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int KIND_W   = 3;
  localparam int SLOTF_W  = 8;
  localparam int PERIOD_W = 16;
  localparam int OFFSET_W = 8;
  localparam int MASK_W   = 16;
  localparam int CNT_W    = 16;
  localparam int DIV_W    = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-3:0] REG_TICK_DIVIDER = '0;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_CREATE = 3'd1,
    KIND_PAUSE  = 3'd2,
    KIND_RESUME = 3'd3,
    KIND_DELETE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                present;
    logic                ready;
    logic [PERIOD_W-1:0] period;
    logic [CNT_W-1:0]    counter;
  } slot_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
  } table_req_t;

endpackage
`default_nettype wire

// ===== sv/ptd_in_if.sv =====
`default_nettype none
interface ptd_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptd_pkg::KIND_W-1:0]   kind;
  logic [ptd_pkg::SLOTF_W-1:0]  slot;
  logic [ptd_pkg::PERIOD_W-1:0] period;
  logic [ptd_pkg::OFFSET_W-1:0] offset;

  modport source (output valid, kind, slot, period, offset, input ready);
  modport sink   (input valid, kind, slot, period, offset, output ready);
endinterface
`default_nettype wire

// ===== sv/ptd_out_if.sv =====
`default_nettype none
interface ptd_out_if;
  logic                       valid;
  logic                       ready;
  logic [ptd_pkg::MASK_W-1:0] fire_mask;
  logic                       scan_done;
  logic                       accepted;

  modport source (output valid, fire_mask, scan_done, accepted, input ready);
  modport sink   (input valid, fire_mask, scan_done, accepted, output ready);
endinterface
`default_nettype wire

// ===== sv/periodic_task_dispatcher.sv =====
// Periodic task dispatcher.
// Transactions arrive on in_chan: a timer tick, or a create, pause, resume or
// delete of one task slot. Every input transaction yields exactly one result
// transaction on out_chan carrying fire_mask, scan_done and accepted.
// The slot table lives in one synchronous memory that is updated by
// read-modify-write. A table operation on a valid slot reads its entry when
// taken and writes it back in ST_OP; a tick that does not reach prescaler
// zero or a rejected operation goes straight to ST_FINISH; a tick that scans
// does one memory read-modify-write per slot in ST_SCAN before ST_FINISH.
// One transaction is processed at a time; in_chan.ready is high while idle.
// The result sits in an output register, so the next transaction is taken
// while a result still waits; if the receiver stalls out_chan, the block
// holds its finished result internally until the output register frees.
// tick_divider is written through the cfg_ APB port at address 0 and also
// reloads the prescaler. Synchronous reset clears all slots at once through
// per-entry valid bits, sets tick_divider and the prescaler to one and
// needs no clearing pass; the block accepts transactions right after reset.
`default_nettype none
module periodic_task_dispatcher (
  input  logic                        clk,
  input  logic                        rst_n,
  ptd_in_if.sink                      in_chan,
  ptd_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ptd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [ptd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [ptd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import ptd_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PERIOD_W-1:0] period_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [SLOT_W-1:0]   scan_idx_r;
  logic [MASK_W-1:0]   res_mask_r;
  logic                res_scan_r;
  logic                res_acc_r;
  logic                out_valid_r;
  logic [MASK_W-1:0]   out_mask_r;
  logic                out_scan_r;
  logic                out_acc_r;
  logic [DIV_W-1:0]    prescale_r, prescale_nxt;
  logic [DIV_W-1:0]    divider_r, divider_nxt;

  table_req_t          tbl_req;
  slot_entry_t         tbl_rd;

  logic                in_take;
  logic                out_free;
  logic                is_tick;
  logic                op_ok;
  logic [DIV_W-1:0]    prescale_dec;
  logic                tick_scan;
  logic                cfg_wr;
  logic                fire;

  ptd_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_take       = in_chan.valid && (state_r == ST_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  assign is_tick      = (in_chan.kind == KIND_TICK);
  assign op_ok        = ((in_chan.kind == KIND_CREATE) || (in_chan.kind == KIND_PAUSE) ||
                         (in_chan.kind == KIND_RESUME) || (in_chan.kind == KIND_DELETE)) &&
                        (in_chan.slot < SLOTF_W'(TASK_SLOTS));
  assign prescale_dec = prescale_r - DIV_W'(1);
  assign tick_scan    = is_tick && (prescale_dec == '0);

  assign fire = tbl_rd.present && tbl_rd.ready && (tbl_rd.counter == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (tick_scan) begin
            state_nxt = ST_SCAN;
          end else if (!is_tick && op_ok) begin
            state_nxt = ST_OP;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_OP: begin
        state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if (scan_idx_r == LAST_SLOT) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tbl_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        tbl_req.rd_en   = in_take && (tick_scan || (!is_tick && op_ok));
        tbl_req.rd_addr = tick_scan ? '0 : in_chan.slot[SLOT_W-1:0];
      end
      ST_OP: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = slot_r;
        tbl_req.wr_data = tbl_rd;
        unique case (kind_r)
          KIND_CREATE: begin
            tbl_req.wr_data.present = 1'b1;
            tbl_req.wr_data.ready   = 1'b1;
            tbl_req.wr_data.period  = period_r;
            tbl_req.wr_data.counter = CNT_W'(offset_r);
          end
          KIND_PAUSE: begin
            tbl_req.wr_data.ready = 1'b0;
          end
          KIND_RESUME: begin
            tbl_req.wr_data.ready   = 1'b1;
            tbl_req.wr_data.counter = '0;
          end
          KIND_DELETE: begin
            tbl_req.wr_data.present = 1'b0;
            tbl_req.wr_data.ready   = 1'b0;
          end
          default: begin
            tbl_req.wr_en = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = scan_idx_r;
        tbl_req.wr_data = tbl_rd;
        tbl_req.wr_data.counter = fire ? (tbl_rd.period - CNT_W'(1))
                                       : (tbl_rd.counter - CNT_W'(1));
        tbl_req.rd_en   = (scan_idx_r != LAST_SLOT);
        tbl_req.rd_addr = scan_idx_r + SLOT_W'(1);
      end
      default: begin
        tbl_req = '0;
      end
    endcase
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_AW-1:2] == REG_TICK_DIVIDER);

  always_comb begin
    priority if (cfg_wr) begin
      prescale_nxt = cfg_pwdata[DIV_W-1:0];
      divider_nxt  = cfg_pwdata[DIV_W-1:0];
    end else if (in_take && is_tick) begin
      prescale_nxt = tick_scan ? divider_r : prescale_dec;
      divider_nxt  = divider_r;
    end else begin
      prescale_nxt = prescale_r;
      divider_nxt  = divider_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prescale_r  <= DIV_W'(1);
      divider_r   <= DIV_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prescale_r <= prescale_nxt;
      divider_r  <= divider_nxt;
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r     <= in_chan.kind;
      slot_r     <= in_chan.slot[SLOT_W-1:0];
      period_r   <= in_chan.period;
      offset_r   <= in_chan.offset;
      scan_idx_r <= '0;
      res_mask_r <= '0;
      res_scan_r <= tick_scan;
      res_acc_r  <= is_tick || op_ok;
    end else if (state_r == ST_SCAN) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
      res_mask_r <= res_mask_r | (MASK_W'(fire) << scan_idx_r);
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_mask_r <= res_mask_r;
      out_scan_r <= res_scan_r;
      out_acc_r  <= res_acc_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.fire_mask = out_mask_r;
  assign out_chan.scan_done = out_scan_r;
  assign out_chan.accepted  = out_acc_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_TICK_DIVIDER) ? CFG_DW'(divider_r) : '0;

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && (scan_idx_r == LAST_SLOT) |=> (state_r == ST_FINISH))
    else $error("scan did not end after the last slot");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_req.wr_en && tbl_req.rd_en |-> (tbl_req.wr_addr != tbl_req.rd_addr))
    else $error("table read and write hit the same slot");

  a_mask_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_mask_r != '0) |-> out_scan_r)
    else $error("fire mask set without a scan");

  a_scan_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scan_r |-> out_acc_r)
    else $error("scan reported for a rejected transaction");

endmodule
`default_nettype wire

// ===== sv/ptd_slot_table.sv =====
`default_nettype none
module ptd_slot_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptd_pkg::table_req_t  req,
  output ptd_pkg::slot_entry_t rd_data
);
  import ptd_pkg::*;

  slot_entry_t           mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld_r;
  slot_entry_t           rd_raw_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // An entry never written since reset reads as an empty slot.
  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule
`default_nettype wire
